// File: rtl/core/dtnm_pkg.sv
// ----------------------------------------------------------------------------
// dtnm_pkg
// shared constants and types of the bad-tower neighbourhood mask block
// ----------------------------------------------------------------------------
package dtnm_pkg;

    localparam int SMALL_ROWS   = 36;
    localparam int SMALL_COLS   = 72;
    localparam int LARGE_ROWS   = 48;
    localparam int LARGE_COLS   = 96;
    localparam int SECTOR_COUNT = 8;

    localparam int SECTOR_W = 3;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int STATUS_W = 16;
    localparam int FLAG_W   = 17;

    // row and column split into quotient and residue by three
    localparam int RQ_W = 5;
    localparam int CQ_W = 6;
    localparam int RES_W = 2;

    localparam int BANK_N     = 3;
    localparam int ADDR_W     = SECTOR_W + RQ_W + CQ_W;
    localparam int BANK_DEPTH = 1 << ADDR_W;

    localparam logic [SECTOR_W-1:0] LARGE_SECTOR_A = 3'd4;
    localparam logic [SECTOR_W-1:0] LARGE_SECTOR_B = 3'd5;
    localparam logic [FLAG_W-1:0]   EDGE_FLAGS     = 17'd512;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CONST = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic                bad;
        logic                pos_ok;
        logic [SECTOR_W-1:0] sector;
        logic [RQ_W-1:0]     rq;
        logic [RES_W-1:0]    rm;
        logic [CQ_W-1:0]     cq;
        logic [RES_W-1:0]    cm;
    } cmd_t;

endpackage

// File: rtl/core/dtnm_ram.sv
// ----------------------------------------------------------------------------
// dtnm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dtnm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/dtnm_front.sv
// ----------------------------------------------------------------------------
// dtnm_front
// accepts input beats, checks position, classifies and splits coordinates
// ----------------------------------------------------------------------------
module dtnm_front (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [dtnm_pkg::SECTOR_W-1:0] sector,
    input  logic [dtnm_pkg::ROW_W-1:0]   row,
    input  logic [dtnm_pkg::COL_W-1:0]   column,
    input  logic signed [dtnm_pkg::STATUS_W-1:0] status,
    input  logic                         q_full,
    input  logic                         clearing,
    output logic                         push,
    output dtnm_pkg::cmd_t               cmd
);
    import dtnm_pkg::*;

    // divide by three through reciprocal multiply, returns {quotient, residue}
    function automatic logic [CQ_W+RES_W-1:0] div3(input logic [COL_W-1:0] v);
        logic [15:0]     prod;
        logic [CQ_W-1:0] q;
        logic [COL_W:0]  three_q;
        logic [COL_W:0]  r;
        prod    = 16'(v) * 16'd171;
        q       = prod[14:9];
        three_q = (COL_W+1)'({q, 1'b0}) + (COL_W+1)'(q);
        r       = (COL_W+1)'(v) - three_q;
        return {q, r[RES_W-1:0]};
    endfunction

    logic                    large_grid;
    logic [ROW_W:0]          n_rows;
    logic [COL_W:0]          n_cols;
    logic                    pos_ok;
    logic                    edge_pos;
    logic [CQ_W+RES_W-1:0]   rsplit;
    logic [CQ_W+RES_W-1:0]   csplit;

    always_comb
    begin
        large_grid = (sector == LARGE_SECTOR_A) || (sector == LARGE_SECTOR_B);
        n_rows = large_grid ? (ROW_W+1)'(LARGE_ROWS) : (ROW_W+1)'(SMALL_ROWS);
        n_cols = large_grid ? (COL_W+1)'(LARGE_COLS) : (COL_W+1)'(SMALL_COLS);
        pos_ok = ({1'b0, sector} < (SECTOR_W+1)'(SECTOR_COUNT))
               && ({1'b0, row} < n_rows) && ({1'b0, column} < n_cols);
        edge_pos = (row <= ROW_W'(1)) || (column <= COL_W'(1))
                 || (({1'b0, row} + (ROW_W+1)'(2)) >= n_rows)
                 || (({1'b0, column} + (COL_W+1)'(2)) >= n_cols);
        rsplit = div3({1'b0, row});
        csplit = div3(column);

        cmd.bad    = (status > 0);
        cmd.pos_ok = pos_ok;
        cmd.sector = sector;
        cmd.rq     = rsplit[RES_W +: RQ_W];
        cmd.rm     = rsplit[RES_W-1:0];
        cmd.cq     = csplit[RES_W +: CQ_W];
        cmd.cm     = csplit[RES_W-1:0];
        if (!mode)
        begin
            cmd.op = OP_WRITE;
        end
        else if (pos_ok && !edge_pos)
        begin
            cmd.op = OP_READ;
        end
        else
        begin
            cmd.op = OP_CONST;
        end
    end

    // writes outside the grid are taken and dropped
    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready && (mode || pos_ok);

endmodule

// File: rtl/core/dtnm_queue.sv
// ----------------------------------------------------------------------------
// dtnm_queue
// two-entry command queue between front and back end
// ----------------------------------------------------------------------------
module dtnm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dtnm_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output dtnm_pkg::cmd_t head
);
    import dtnm_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

endmodule

// File: rtl/core/dtnm_back.sv
// ----------------------------------------------------------------------------
// dtnm_back
// clears and updates the nine banked mark stores, reads neighbourhoods
// ----------------------------------------------------------------------------
module dtnm_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  dtnm_pkg::cmd_t             head,
    output logic                       pop,
    output logic                       clearing,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dtnm_pkg::FLAG_W-1:0] flag_bits,
    output logic                       position_valid
);
    import dtnm_pkg::*;

    localparam logic [1:0] OFF_ZERO  = 2'd0;
    localparam logic [1:0] OFF_PLUS  = 2'd1;
    localparam logic [1:0] OFF_MINUS = 2'd2;

    // which neighbour offset a bank holds, given the centre residue
    function automatic logic [1:0] bank_off(input logic [1:0] bank, input logic [1:0] res);
        logic [2:0] t;
        t = 3'(bank) + 3'd3 - 3'(res);
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    logic              clr_reg, clr_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              pend_reg, pend_next;
    logic [RES_W-1:0]  pend_rm_reg, pend_rm_next;
    logic [RES_W-1:0]  pend_cm_reg, pend_cm_next;
    logic              out_valid_reg, out_valid_next;
    logic [FLAG_W-1:0] out_flags_reg, out_flags_next;
    logic              out_pv_reg, out_pv_next;

    logic              out_free;
    logic [FLAG_W-1:0] nb_mask;
    logic [RQ_W-1:0]   row_q [BANK_N];
    logic [CQ_W-1:0]   col_q [BANK_N];
    logic              rd_bit [BANK_N][BANK_N];

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        pop = 1'b0;
        if (!clr_reg && head_valid && !pend_reg)
        begin
            case (head.op)
                OP_WRITE: pop = 1'b1;
                OP_READ:  pop = 1'b1;
                OP_CONST: pop = out_free;
                default:  pop = 1'b1;
            endcase
        end
    end

    // per-bank quotients of the neighbour row and column
    always_comb
    begin
        for (int i = 0; i < BANK_N; i++)
        begin
            case (bank_off(2'(i), head.rm))
                OFF_PLUS:  row_q[i] = head.rq + RQ_W'(head.rm == 2'd2);
                OFF_MINUS: row_q[i] = head.rq - RQ_W'(head.rm == 2'd0);
                default:   row_q[i] = head.rq;
            endcase
            case (bank_off(2'(i), head.cm))
                OFF_PLUS:  col_q[i] = head.cq + CQ_W'(head.cm == 2'd2);
                OFF_MINUS: col_q[i] = head.cq - CQ_W'(head.cm == 2'd0);
                default:   col_q[i] = head.cq;
            endcase
        end
    end

    for (genvar gi = 0; gi < BANK_N; gi++)
    begin : g_row
        for (genvar gj = 0; gj < BANK_N; gj++)
        begin : g_col
            logic              we;
            logic [ADDR_W-1:0] addr;
            logic              wdata;

            always_comb
            begin
                addr = {head.sector, row_q[gi], col_q[gj]};
                if (clr_reg)
                begin
                    we    = 1'b1;
                    wdata = 1'b0;
                end
                else
                begin
                    we    = pop && (head.op == OP_WRITE)
                          && (head.rm == 2'(gi)) && (head.cm == 2'(gj));
                    wdata = head.bad;
                end
            end

            dtnm_ram #(
                .WIDTH (1),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .clk   (clk),
                .we    (we),
                .waddr (clr_reg ? clr_cnt_reg : addr),
                .wdata (wdata),
                .re    (pop && (head.op == OP_READ)),
                .raddr (addr),
                .rdata (rd_bit[gi][gj])
            );
        end
    end

    // place each bank bit at its neighbourhood position
    always_comb
    begin
        logic [1:0] dr;
        logic [1:0] dc;
        logic [4:0] pos;
        nb_mask = '0;
        for (int i = 0; i < BANK_N; i++)
        begin
            for (int j = 0; j < BANK_N; j++)
            begin
                dr = bank_off(2'(i), pend_rm_reg);
                dc = bank_off(2'(j), pend_cm_reg);
                case (dr)
                    OFF_MINUS: pos = 5'd4;
                    OFF_PLUS:  pos = 5'd14;
                    default:   pos = 5'd9;
                endcase
                case (dc)
                    OFF_ZERO: pos = pos + 5'd1;
                    OFF_PLUS: pos = pos + 5'd2;
                    default:  pos = pos;
                endcase
                nb_mask[pos] = rd_bit[i][j];
            end
        end
    end

    always_comb
    begin
        clr_next       = clr_reg && !(&clr_cnt_reg);
        clr_cnt_next   = clr_reg ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;
        pend_next      = pend_reg;
        pend_rm_next   = pend_rm_reg;
        pend_cm_next   = pend_cm_reg;
        out_valid_next = out_valid_reg;
        out_flags_next = out_flags_reg;
        out_pv_next    = out_pv_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pend_reg && out_free)
        begin
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
            out_flags_next = nb_mask;
            out_pv_next    = 1'b1;
        end
        else if (pop && (head.op == OP_CONST))
        begin
            out_valid_next = 1'b1;
            out_flags_next = head.pos_ok ? EDGE_FLAGS : '0;
            out_pv_next    = head.pos_ok;
        end
        else if (pop && (head.op == OP_READ))
        begin
            pend_next    = 1'b1;
            pend_rm_next = head.rm;
            pend_cm_next = head.cm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rm_reg   <= pend_rm_next;
        pend_cm_reg   <= pend_cm_next;
        out_flags_reg <= out_flags_next;
        out_pv_reg    <= out_pv_next;
    end

    assign clearing       = clr_reg;
    assign out_valid      = out_valid_reg;
    assign flag_bits      = out_flags_reg;
    assign position_valid = out_pv_reg;

endmodule

// File: rtl/core/dead_tower_neighbourhood_mask.sv
// ----------------------------------------------------------------------------
// dead_tower_neighbourhood_mask
// bad-tower map with 3x3 neighbourhood mask queries
// ----------------------------------------------------------------------------
// After reset the block sweeps all 16384 entries of its mark store clear with
// in_ready low. A write beat ends when the back end takes it; a query of an
// interior tower reads the nine row/column banks, then combines the bits into
// flag_bits once the output register is free; an edge or out-of-grid query
// skips the bank read. No new command is taken while a read waits. A two-entry
// queue lets input beats be taken while a result waits on out_ready. Writes
// outside the grid are taken and dropped without a result.
module dead_tower_neighbourhood_mask (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [dtnm_pkg::SECTOR_W-1:0] sector,
    input  logic [dtnm_pkg::ROW_W-1:0]    row,
    input  logic [dtnm_pkg::COL_W-1:0]    column,
    input  logic signed [dtnm_pkg::STATUS_W-1:0] status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dtnm_pkg::FLAG_W-1:0]   flag_bits,
    output logic                          position_valid
);
    import dtnm_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic head_valid;
    logic clearing;
    cmd_t push_cmd;
    cmd_t head;

    dtnm_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .sector   (sector),
        .row      (row),
        .column   (column),
        .status   (status),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (push),
        .cmd      (push_cmd)
    );

    dtnm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    dtnm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .clearing       (clearing),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .flag_bits      (flag_bits),
        .position_valid (position_valid)
    );

endmodule

// File: rtl/core/dtnm_checker.sv
// ----------------------------------------------------------------------------
// dtnm_checker
// port-level checks of the neighbourhood mask block, bound to the top level
// ----------------------------------------------------------------------------
module dtnm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          mode,
    input logic [dtnm_pkg::SECTOR_W-1:0] sector,
    input logic [dtnm_pkg::ROW_W-1:0]    row,
    input logic [dtnm_pkg::COL_W-1:0]    column,
    input logic signed [dtnm_pkg::STATUS_W-1:0] status,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dtnm_pkg::FLAG_W-1:0]   flag_bits,
    input logic                          position_valid
);
    import dtnm_pkg::*;

    localparam logic [FLAG_W-1:0] NB_BITS = 17'h1CE70;

    // off-grid answer carries no marks
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !position_valid |-> flag_bits == '0)
        else $error("off-grid result with nonzero flags");

    // only the nine neighbourhood bits may be set
    a_mask_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flag_bits & ~NB_BITS) == '0)
        else $error("flag bits outside the neighbourhood");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(flag_bits)
            && $stable(position_valid))
        else $error("result beat changed while stalled");

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(sector)
            && $stable(row) && $stable(column) && $stable(status))
        else $error("input beat changed while stalled");

endmodule

bind dead_tower_neighbourhood_mask dtnm_checker u_dtnm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .sector         (sector),
    .row            (row),
    .column         (column),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .flag_bits      (flag_bits),
    .position_valid (position_valid)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the bad-tower neighbourhood mask block against a bit-level predictor
// ----------------------------------------------------------------------------
// Status writes and mask queries go in through a valid/ready input channel.
// A scoreboard keeps its own copy of the bad-tower map and works out the
// mask that each accepted query should return. Results are compared in
// order, field by field. Stimulus starts with a directed set of edge,
// interior and out-of-grid cases. A random part follows that writes and
// queries around moving hot spots, with some edge and unconstrained beats.
// Both sides idle at random. The receiver also holds off once for a long
// stretch, and the sender pauses once until the block has drained.
// ----------------------------------------------------------------------------
module testbench;

    import dtnm_pkg::*;

    localparam bit MODE_WRITE = 1'b0;
    localparam bit MODE_QUERY = 1'b1;

    localparam int RANDOM_BEATS   = 430;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 50000;

    typedef struct {
        logic [FLAG_W-1:0] flags;
        logic              pos_ok;
    } mask_t;

    class tower_mask_board;
        bit    marks [8][64][128];
        mask_t awaited_masks [$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        static function int rows_of(int s);
            return (s == LARGE_SECTOR_A || s == LARGE_SECTOR_B) ? LARGE_ROWS : SMALL_ROWS;
        endfunction

        static function int cols_of(int s);
            return (s == LARGE_SECTOR_A || s == LARGE_SECTOR_B) ? LARGE_COLS : SMALL_COLS;
        endfunction

        function int pending();
            return awaited_masks.size();
        endfunction

        function void note_beat(bit m, bit [SECTOR_W-1:0] s, bit [ROW_W-1:0] r,
                                bit [COL_W-1:0] c, logic signed [STATUS_W-1:0] st);
            int    rows;
            int    cols;
            bit    in_grid;
            mask_t want;
            rows = rows_of(s);
            cols = cols_of(s);
            in_grid = (s < SECTOR_COUNT) && (r < rows) && (c < cols);
            if (m == MODE_WRITE)
            begin
                if (in_grid)
                    marks[s][r][c] = (st > 0);
                return;
            end
            want.flags  = '0;
            want.pos_ok = 1'b0;
            if (in_grid)
            begin
                want.pos_ok = 1'b1;
                if (r <= 1 || c <= 1 || r + 1 >= rows - 1 || c + 1 >= cols - 1)
                    want.flags = EDGE_FLAGS;
                else
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            want.flags[10 + 5 * dr + dc] = marks[s][r + dr][c + dc];
            end
            awaited_masks.push_back(want);
        endfunction

        function void check_mask(logic [FLAG_W-1:0] f, logic pv);
            mask_t want;
            if (awaited_masks.size() == 0)
            begin
                $error("unexpected result beat: flag_bits %0h position_valid %0b", f, pv);
                errors++;
                return;
            end
            want = awaited_masks.pop_front();
            if (f !== want.flags)
            begin
                $error("flag_bits: expected %05h, got %05h", want.flags, f);
                errors++;
            end
            if (pv !== want.pos_ok)
            begin
                $error("position_valid: expected %0b, got %0b", want.pos_ok, pv);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       mode;
    logic [SECTOR_W-1:0]        sector;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           column;
    logic signed [STATUS_W-1:0] status;
    logic                       out_valid;
    logic                       out_ready;
    logic [FLAG_W-1:0]          flag_bits;
    logic                       position_valid;

    tower_mask_board board = new();

    bit tx_calm     = 1'b0;
    bit rx_hold_req = 1'b0;
    int idle_cycles = 0;

    dead_tower_neighbourhood_mask dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .sector         (sector),
        .row            (row),
        .column         (column),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .flag_bits      (flag_bits),
        .position_valid (position_valid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_beat(mode, sector, row, column, status);
            if (out_valid && out_ready)
                board.check_mask(flag_bits, position_valid);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side
    initial
    begin
        int gap;
        int rx_count;
        rx_count = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ((rx_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            rx_count++;
        end
    end

    task automatic send_beat(bit m, bit [SECTOR_W-1:0] s, bit [ROW_W-1:0] r,
                             bit [COL_W-1:0] c, logic signed [STATUS_W-1:0] st);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode     <= m;
        sector   <= s;
        row      <= r;
        column   <= c;
        status   <= st;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
    endtask

    initial
    begin
        int hot_s;
        int hot_r;
        int hot_c;
        int s;
        int r;
        int c;
        int burst;
        bit m;
        logic signed [STATUS_W-1:0] st;
        burst = 0;
        hot_s = 0;
        hot_r = 2;
        hot_c = 2;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        mode     = MODE_WRITE;
        sector   = '0;
        row      = '0;
        column   = '0;
        status   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // status extremes and clearing a mark
        send_beat(MODE_WRITE, 3'd0, 6'd5, 7'd5, 16'sh7fff);
        send_beat(MODE_WRITE, 3'd0, 6'd5, 7'd6, 16'sd1);
        send_beat(MODE_WRITE, 3'd0, 6'd4, 7'd4, 16'sd1);
        send_beat(MODE_WRITE, 3'd0, 6'd6, 7'd6, 16'sd1);
        send_beat(MODE_WRITE, 3'd0, 6'd6, 7'd6, 16'sd0);
        send_beat(MODE_WRITE, 3'd0, 6'd4, 7'd6, -16'sd1);
        send_beat(MODE_WRITE, 3'd0, 6'd6, 7'd4, 16'sh8000);
        send_beat(MODE_QUERY, 3'd0, 6'd5, 7'd5, 16'sd0);
        // large grid, interior next to the edge band
        send_beat(MODE_WRITE, 3'd4, 6'd46, 7'd94, 16'sd1);
        send_beat(MODE_WRITE, 3'd4, 6'd45, 7'd93, 16'sd1);
        send_beat(MODE_QUERY, 3'd4, 6'd45, 7'd93, 16'sd0);
        send_beat(MODE_QUERY, 3'd5, 6'd2, 7'd2, 16'sd0);
        send_beat(MODE_QUERY, 3'd0, 6'd33, 7'd69, 16'sd0);
        // edge band
        send_beat(MODE_QUERY, 3'd4, 6'd46, 7'd50, 16'sd0);
        send_beat(MODE_QUERY, 3'd0, 6'd0, 7'd0, 16'sd0);
        send_beat(MODE_QUERY, 3'd0, 6'd1, 7'd10, 16'sd0);
        send_beat(MODE_QUERY, 3'd1, 6'd35, 7'd10, 16'sd0);
        send_beat(MODE_QUERY, 3'd2, 6'd10, 7'd70, 16'sd0);
        send_beat(MODE_QUERY, 3'd3, 6'd10, 7'd71, 16'sd0);
        send_beat(MODE_QUERY, 3'd7, 6'd34, 7'd70, 16'sd0);
        // outside the grid
        send_beat(MODE_WRITE, 3'd7, 6'd63, 7'd127, -16'sd1);
        send_beat(MODE_WRITE, 3'd1, 6'd40, 7'd5, 16'sd1);
        send_beat(MODE_QUERY, 3'd0, 6'd36, 7'd10, 16'sd0);
        send_beat(MODE_QUERY, 3'd6, 6'd10, 7'd72, 16'sd0);
        send_beat(MODE_QUERY, 3'd5, 6'd63, 7'd127, 16'sd0);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 40 == 0)
            begin
                hot_s = $urandom_range(0, 7);
                hot_r = $urandom_range(2, tower_mask_board::rows_of(hot_s) - 3);
                hot_c = $urandom_range(2, tower_mask_board::cols_of(hot_s) - 3);
            end
            if (i == 150)
            begin
                rx_hold_req = 1'b1;
                burst = 16;
            end
            if (i == 300)
                drain_results();
            tx_calm = ((i / 60) % 3 == 1) || (burst > 0);

            st = ($urandom_range(0, 9) == 0) ? 16'sd0 : STATUS_W'($urandom);
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    s = $urandom_range(0, 7);
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 127);
                    m = 1'($urandom_range(0, 1));
                end
                3, 4, 5:
                begin
                    s = $urandom_range(0, 7);
                    r = $urandom_range(0, tower_mask_board::rows_of(s) - 1);
                    c = $urandom_range(0, tower_mask_board::cols_of(s) - 1);
                    case ($urandom_range(0, 3))
                        0: r = $urandom_range(0, 1);
                        1: r = tower_mask_board::rows_of(s) - 2 + $urandom_range(0, 1);
                        2: c = $urandom_range(0, 1);
                        default: c = tower_mask_board::cols_of(s) - 2 + $urandom_range(0, 1);
                    endcase
                    m = ($urandom_range(0, 3) != 0) ? MODE_QUERY : MODE_WRITE;
                end
                default:
                begin
                    s = hot_s;
                    r = hot_r + $urandom_range(0, 4) - 2;
                    c = hot_c + $urandom_range(0, 4) - 2;
                    m = 1'($urandom_range(0, 1));
                end
            endcase
            if (burst > 0)
            begin
                m = MODE_QUERY;
                burst--;
            end
            send_beat(m, SECTOR_W'(s), ROW_W'(r), COL_W'(c), st);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
